[rtl/pct_pkg.sv]
// pct_pkg: shared types and codes for the preset countdown timer
// used by every module of the timer; depends on nothing
`timescale 1ns / 1ps

package pct_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_PRESET_A     = 3'd0;
  localparam logic [2:0] CFG_PRESET_B     = 3'd1;
  localparam logic [2:0] CFG_PRESET_C     = 3'd2;
  localparam logic [2:0] CFG_TICKS_PER_S  = 3'd3;
  localparam logic [2:0] CFG_FLICKER_HALF = 3'd4;
  localparam logic [2:0] CFG_SCAN_PERIOD  = 3'd5;

  // key edge codes
  localparam logic [2:0] KEY_START  = 3'd1;
  localparam logic [2:0] KEY_RELOAD = 3'd2;
  localparam logic [2:0] KEY_MODE   = 3'd3;
  localparam logic [2:0] KEY_NEXT   = 3'd4;

  // display codes
  localparam logic [1:0] MODE_DISPLAY = 2'd1;
  localparam logic [1:0] MODE_SET     = 2'd2;
  localparam logic [3:0] DIGIT_BLANK  = 4'd10;

  // preset index codes
  localparam logic [1:0] PRESET_IDX_A = 2'd0;
  localparam logic [1:0] PRESET_IDX_B = 2'd1;
  localparam logic [1:0] PRESET_IDX_C = 2'd2;

  // reset values
  localparam logic [6:0] SECONDS_RESET = 7'd30;

  typedef struct packed {
    logic [6:0] preset_a;
    logic [6:0] preset_b;
    logic [6:0] preset_c;
    logic [9:0] ticks_per_second;
    logic [9:0] flicker_half_period;
    logic [3:0] scan_period;
  } cfg_t;

  // updated timer state that the result is formed from
  typedef struct packed {
    logic       set_mode;
    logic       flicker_phase;
    logic       started;
    logic [6:0] seconds_left;
    logic [6:0] chosen_preset;
  } view_t;

endpackage

[rtl/pct_cfg_regs.sv]
// pct_cfg_regs: configuration register file of the preset countdown timer
// depends on pct_pkg for register indexes and the cfg_t struct
`timescale 1ns / 1ps

module pct_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [9:0]    cfg_data_i,
  output pct_pkg::cfg_t cfg_o
);
  import pct_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.preset_a            <= 7'd15;
      cfg_q.preset_b            <= 7'd30;
      cfg_q.preset_c            <= 7'd60;
      cfg_q.ticks_per_second    <= 10'd1000;
      cfg_q.flicker_half_period <= 10'd500;
      cfg_q.scan_period         <= 4'd10;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PRESET_A:     cfg_q.preset_a            <= cfg_data_i[6:0];
        CFG_PRESET_B:     cfg_q.preset_b            <= cfg_data_i[6:0];
        CFG_PRESET_C:     cfg_q.preset_c            <= cfg_data_i[6:0];
        CFG_TICKS_PER_S:  cfg_q.ticks_per_second    <= cfg_data_i;
        CFG_FLICKER_HALF: cfg_q.flicker_half_period <= cfg_data_i;
        CFG_SCAN_PERIOD:  cfg_q.scan_period         <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/pct_core.sv]
// pct_core: key scan, countdown and flicker state of the timer
// depends on pct_pkg for key codes, cfg_t and view_t
`timescale 1ns / 1ps

module pct_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           tick_i,
  input  logic [2:0]     key_code_i,
  input  pct_pkg::cfg_t  cfg_i,
  output pct_pkg::view_t view_o
);
  import pct_pkg::*;

  logic [2:0] last_key_q, last_key_d;
  logic [3:0] scan_cnt_q, scan_cnt_d;
  logic [9:0] ms_cnt_q, ms_cnt_d;
  logic [6:0] seconds_q, seconds_d;
  logic       set_mode_q, set_mode_d;
  logic       started_q, started_d;
  logic [1:0] preset_idx_q, preset_idx_d;
  logic [9:0] flick_cnt_q, flick_cnt_d;
  logic       phase_q, phase_d;

  logic [2:0] key_edge;
  logic [6:0] chosen_now;
  logic [6:0] chosen_next;
  logic [6:0] seconds_scan;
  logic [3:0] scan_inc;
  logic [9:0] ms_inc;
  logic [9:0] flick_inc;

  // preset selected by the stored and the updated index
  always_comb begin
    case (preset_idx_q)
      PRESET_IDX_A: chosen_now = cfg_i.preset_a;
      PRESET_IDX_B: chosen_now = cfg_i.preset_b;
      default:      chosen_now = cfg_i.preset_c;
    endcase
    case (preset_idx_d)
      PRESET_IDX_A: chosen_next = cfg_i.preset_a;
      PRESET_IDX_B: chosen_next = cfg_i.preset_b;
      default:      chosen_next = cfg_i.preset_c;
    endcase
  end

  // key scan on newly pressed bits
  assign key_edge = key_code_i & (key_code_i ^ last_key_q);

  always_comb begin
    last_key_d   = last_key_q;
    set_mode_d   = set_mode_q;
    started_d    = started_q;
    preset_idx_d = preset_idx_q;
    seconds_scan = seconds_q;
    if (scan_cnt_q == 4'd0) begin
      last_key_d = key_code_i;
      case (key_edge)
        KEY_START: begin
          if (!set_mode_q) started_d = 1'b1;
        end
        KEY_RELOAD: begin
          if (!set_mode_q) seconds_scan = chosen_now;
        end
        KEY_MODE: begin
          if (set_mode_q) seconds_scan = chosen_now;
          set_mode_d = ~set_mode_q;
        end
        KEY_NEXT: begin
          if (set_mode_q) begin
            preset_idx_d = (preset_idx_q >= PRESET_IDX_C) ? PRESET_IDX_A
                                                         : preset_idx_q + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // scan period counter
  assign scan_inc   = scan_cnt_q + 4'd1;
  assign scan_cnt_d = (scan_inc >= cfg_i.scan_period) ? 4'd0 : scan_inc;

  // one-second countdown, saturating at zero
  assign ms_inc = ms_cnt_q + 10'd1;
  always_comb begin
    ms_cnt_d  = ms_cnt_q;
    seconds_d = seconds_scan;
    if (started_d) begin
      ms_cnt_d = ms_inc;
      if (ms_inc >= cfg_i.ticks_per_second) begin
        ms_cnt_d = 10'd0;
        if (seconds_scan != 7'd0) seconds_d = seconds_scan - 7'd1;
      end
    end
  end

  // set-mode blink phase
  assign flick_inc = flick_cnt_q + 10'd1;
  always_comb begin
    flick_cnt_d = flick_inc;
    phase_d     = phase_q;
    if (flick_inc >= cfg_i.flicker_half_period) begin
      flick_cnt_d = 10'd0;
      phase_d     = ~phase_q;
    end
  end

  // state advances once per accepted tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_key_q   <= 3'd0;
      scan_cnt_q   <= 4'd0;
      ms_cnt_q     <= 10'd0;
      seconds_q    <= SECONDS_RESET;
      set_mode_q   <= 1'b0;
      started_q    <= 1'b0;
      preset_idx_q <= PRESET_IDX_B;
      flick_cnt_q  <= 10'd0;
      phase_q      <= 1'b0;
    end else if (tick_i) begin
      last_key_q   <= last_key_d;
      scan_cnt_q   <= scan_cnt_d;
      ms_cnt_q     <= ms_cnt_d;
      seconds_q    <= seconds_d;
      set_mode_q   <= set_mode_d;
      started_q    <= started_d;
      preset_idx_q <= preset_idx_d;
      flick_cnt_q  <= flick_cnt_d;
      phase_q      <= phase_d;
    end
  end

  // updated state for the result of this tick
  assign view_o.set_mode      = set_mode_d;
  assign view_o.flicker_phase = phase_d;
  assign view_o.started       = started_d;
  assign view_o.seconds_left  = seconds_d;
  assign view_o.chosen_preset = chosen_next;

endmodule

[rtl/pct_digits.sv]
// pct_digits: splits a 7-bit value into tens and ones digits, with blanking
// depends on pct_pkg for the blank digit code
`timescale 1ns / 1ps

module pct_digits (
  input  logic [6:0] value_i,
  input  logic       blank_i,
  output logic [3:0] tens_o,
  output logic [3:0] ones_o
);
  import pct_pkg::*;

  logic [14:0] prod;
  logic [3:0]  quot;
  logic [3:0]  tens;
  logic [6:0]  quot_x10;
  logic [6:0]  rem;

  // value / 10 as multiply by 205 and shift by 11, exact below 1029
  assign prod     = 15'(value_i) * 15'd205;
  assign quot     = prod[14:11];
  assign tens     = (quot >= 4'd10) ? quot - 4'd10 : quot;
  assign quot_x10 = {quot[3:0], 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = value_i - quot_x10;

  assign tens_o = blank_i ? DIGIT_BLANK : tens;
  assign ones_o = blank_i ? DIGIT_BLANK : rem[3:0];

endmodule

[rtl/preset_countdown_timer.sv]
// preset_countdown_timer: top level of the preset countdown timer
// instantiates pct_cfg_regs, pct_core and pct_digits; depends on pct_pkg
//
// Usage:
//   Each word on the input channel (in_valid_i / in_ready_o, key_code_i) is
//   one millisecond tick carrying the pressed key. Every accepted tick gives
//   exactly one result word on the output channel (out_valid_o /
//   out_ready_i): mode digit, two count digits, alarm and running flags.
//   Registers are written over the cfg channel (cfg_valid_i / cfg_ready_o,
//   cfg_index_i, cfg_data_i); the user must do so only while the block is
//   idle, as the block does not enforce it; cfg_ready_o is always high.
//   A tick accepted at an edge shows its result from that edge on. Throughput
//   is one tick per cycle while the receiver takes every word; the timer state
//   and the output register both load on the same edge.
//   Reset clears the timer state to display mode, 30 seconds, preset B, and
//   loads the reset register values; the output register is empty.
//   When the receiver stalls the output register holds its word and the
//   input channel is still ready only if that word is taken in the same
//   cycle.
`timescale 1ns / 1ps

module preset_countdown_timer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [9:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] key_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] mode_digit_o,
  output logic [3:0] tens_digit_o,
  output logic [3:0] ones_digit_o,
  output logic       alarm_o,
  output logic       running_o
);
  import pct_pkg::*;

  cfg_t       cfg;
  view_t      view;
  logic       tick;
  logic [6:0] shown;
  logic [3:0] tens;
  logic [3:0] ones;

  logic       out_valid_q;
  logic [1:0] mode_q;
  logic [3:0] tens_q;
  logic [3:0] ones_q;
  logic       alarm_q;
  logic       running_q;

  // handshake: accept while the output register is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign tick       = in_valid_i && in_ready_o;

  pct_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pct_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (tick),
    .key_code_i (key_code_i),
    .cfg_i      (cfg),
    .view_o     (view)
  );

  // count in display mode, chosen preset in set mode
  assign shown = view.set_mode ? view.chosen_preset : view.seconds_left;

  pct_digits u_digits (
    .value_i (shown),
    .blank_i (view.set_mode && view.flicker_phase),
    .tens_o  (tens),
    .ones_o  (ones)
  );

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (tick) begin
      mode_q    <= view.set_mode ? MODE_SET : MODE_DISPLAY;
      tens_q    <= tens;
      ones_q    <= ones;
      alarm_q   <= (view.seconds_left == 7'd0);
      running_q <= view.started;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign mode_digit_o = mode_q;
  assign tens_digit_o = tens_q;
  assign ones_digit_o = ones_q;
  assign alarm_o      = alarm_q;
  assign running_o    = running_q;

endmodule

[rtl/pct_checker.sv]
// pct_checker: port-level assertions for the preset countdown timer
// depends on pct_pkg for display codes; bound to preset_countdown_timer
`timescale 1ns / 1ps

module pct_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] mode_digit_o,
  input logic [3:0] tens_digit_o,
  input logic [3:0] ones_digit_o,
  input logic       alarm_o,
  input logic       running_o
);
  import pct_pkg::*;

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(mode_digit_o) &&
      $stable(tens_digit_o) && $stable(ones_digit_o) && $stable(alarm_o) &&
      $stable(running_o))
    else $error("stalled result word changed");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // alarm in display mode shows a zero count
  a_alarm_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && alarm_o && mode_digit_o == MODE_DISPLAY |->
      tens_digit_o == 4'd0 && ones_digit_o == 4'd0)
    else $error("alarm with nonzero count");

  // once running, every later word is running
  a_running_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && running_o |=> !out_valid_o || running_o)
    else $error("running flag dropped");

endmodule

bind preset_countdown_timer pct_checker u_pct_checker (.*);

[tb/testbench.sv]
// testbench: self-checking bench for the preset countdown timer
// key ticks come from a queue and are checked against a timer predictor;
// depends on pct_pkg and preset_countdown_timer
`timescale 1ns / 1ps

module testbench;
  import pct_pkg::*;

  // one result word as shown on the display side
  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] tens;
    logic [3:0] ones;
    logic       alarm;
    logic       running;
  } readout_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [2:0] cfg_index_i = CFG_PRESET_A;
  logic [9:0] cfg_data_i  = 10'd0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [2:0] key_code_i  = 3'd0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] mode_digit_o;
  logic [3:0] tens_digit_o;
  logic [3:0] ones_digit_o;
  logic       alarm_o;
  logic       running_o;

  preset_countdown_timer u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .key_code_i   (key_code_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .mode_digit_o (mode_digit_o),
    .tens_digit_o (tens_digit_o),
    .ones_digit_o (ones_digit_o),
    .alarm_o      (alarm_o),
    .running_o    (running_o)
  );

  // clock
  always #10 clk_i = ~clk_i;

  // predictor copy of the registers and the timer state
  cfg_t       tmr_cfg;
  logic [2:0] last_key;
  logic [3:0] scan_cnt;
  logic [9:0] ms_cnt;
  logic [6:0] secs_left;
  logic       set_mode;
  logic       started;
  logic [1:0] preset_sel;
  logic [9:0] flick_cnt;
  logic       flick_phase;

  logic [2:0] key_queue[$];
  readout_t   readout_due[$];
  int         error_count    = 0;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         key_taken      = 1'b0;
  bit         hold_armed     = 1'b0;
  bit         hold_active    = 1'b0;

  function automatic logic [6:0] chosen_preset();
    case (preset_sel)
      PRESET_IDX_A: return tmr_cfg.preset_a;
      PRESET_IDX_B: return tmr_cfg.preset_b;
      default:      return tmr_cfg.preset_c;
    endcase
  endfunction

  // one millisecond tick of the timer; queues the readout it gives
  task automatic advance_timer(input logic [2:0] key);
    logic [2:0] edge_code;
    logic [6:0] shown;
    readout_t   want;
    // key scan with edge test against the last scan
    if (scan_cnt == 4'd0) begin
      edge_code = key & (key ^ last_key);
      last_key  = key;
      case (edge_code)
        KEY_START: begin
          if (!set_mode) started = 1'b1;
        end
        KEY_RELOAD: begin
          if (!set_mode) secs_left = chosen_preset();
        end
        KEY_MODE: begin
          if (set_mode) secs_left = chosen_preset();
          set_mode = ~set_mode;
        end
        KEY_NEXT: begin
          if (set_mode)
            preset_sel = (preset_sel >= PRESET_IDX_C) ? PRESET_IDX_A : preset_sel + 2'd1;
        end
        default: ;
      endcase
    end
    scan_cnt = scan_cnt + 4'd1;
    if (scan_cnt >= tmr_cfg.scan_period) scan_cnt = 4'd0;
    // countdown, saturating at zero
    if (started) begin
      ms_cnt = ms_cnt + 10'd1;
      if (ms_cnt >= tmr_cfg.ticks_per_second) begin
        ms_cnt = 10'd0;
        if (secs_left != 7'd0) secs_left = secs_left - 7'd1;
      end
    end
    // blink phase
    flick_cnt = flick_cnt + 10'd1;
    if (flick_cnt >= tmr_cfg.flicker_half_period) begin
      flick_cnt   = 10'd0;
      flick_phase = ~flick_phase;
    end
    // readout from the updated state
    want.mode = set_mode ? MODE_SET : MODE_DISPLAY;
    if (set_mode && flick_phase) begin
      want.tens = DIGIT_BLANK;
      want.ones = DIGIT_BLANK;
    end else begin
      shown     = set_mode ? chosen_preset() : secs_left;
      want.tens = 4'((shown / 7'd10) % 7'd10);
      want.ones = 4'(shown % 7'd10);
    end
    want.alarm   = (secs_left == 7'd0);
    want.running = started;
    readout_due.push_back(want);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      error_count++;
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // driver: offers queued key ticks, holding each word until taken
  always @(negedge clk_i) begin
    if (!in_valid_i || key_taken) begin
      if (key_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        key_code_i <= key_queue.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    key_taken = 1'b0;
  end

  // receiver: random stalls plus the long hold-off
  always @(negedge clk_i) begin
    out_ready_i <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  // long hold-off of the receiver, counted in cycles
  initial begin : long_hold
    wait (hold_armed);
    @(posedge clk_i);
    hold_active = 1'b1;
    repeat (300) @(posedge clk_i);
    hold_active = 1'b0;
  end

  // monitor: check taken results, then predict newly taken ticks
  always @(posedge clk_i) begin : monitor
    readout_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (readout_due.size() == 0) begin
          error_count++;
          $display("%0t ns: unexpected result, mode %0d tens %0d ones %0d", $time,
                   mode_digit_o, tens_digit_o, ones_digit_o);
        end else begin
          want = readout_due.pop_front();
          check_field("mode_digit", int'(want.mode), int'(mode_digit_o));
          check_field("tens_digit", int'(want.tens), int'(tens_digit_o));
          check_field("ones_digit", int'(want.ones), int'(ones_digit_o));
          check_field("alarm", int'(want.alarm), int'(alarm_o));
          check_field("running", int'(want.running), int'(running_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        advance_timer(key_code_i);
        key_taken = 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_PRESET_A:     tmr_cfg.preset_a            = val[6:0];
      CFG_PRESET_B:     tmr_cfg.preset_b            = val[6:0];
      CFG_PRESET_C:     tmr_cfg.preset_c            = val[6:0];
      CFG_TICKS_PER_S:  tmr_cfg.ticks_per_second    = val;
      CFG_FLICKER_HALF: tmr_cfg.flicker_half_period = val;
      CFG_SCAN_PERIOD:  tmr_cfg.scan_period         = val[3:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [6:0] pa, input logic [6:0] pb, input logic [6:0] pc,
                           input logic [9:0] tps, input logic [9:0] fl, input logic [3:0] sp);
    write_reg(CFG_PRESET_A, {3'd0, pa});
    write_reg(CFG_PRESET_B, {3'd0, pb});
    write_reg(CFG_PRESET_C, {3'd0, pc});
    write_reg(CFG_TICKS_PER_S, tps);
    write_reg(CFG_FLICKER_HALF, fl);
    write_reg(CFG_SCAN_PERIOD, {6'd0, sp});
  endtask

  // wait until every queued tick is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk_i);
    while (key_queue.size() != 0 || in_valid_i || readout_due.size() != 0);
  endtask

  function automatic logic [6:0] pick_preset();
    if ($urandom_range(99) < 85) return 7'($urandom_range(0, 20));
    return 7'($urandom_range(0, 127));
  endfunction

  // key presses held over several scans, with releases, stray codes and
  // short taps that a scan may miss
  task automatic queue_key_runs(input int ticks);
    int         pushed;
    int         run;
    int         r;
    int         scan_eff;
    logic [2:0] k;
    pushed   = 0;
    scan_eff = (tmr_cfg.scan_period == 4'd0) ? 1 : int'(tmr_cfg.scan_period);
    while (pushed < ticks) begin
      r = $urandom_range(99);
      if (r < 30) k = 3'd0;
      else if (r < 88) k = 3'($urandom_range(1, 4));
      else k = 3'($urandom_range(5, 7));
      run = (r % 7 == 0) ? 1 : $urandom_range(1, 2 * scan_eff + 1);
      repeat (run) begin
        key_queue.push_back(k);
        pushed++;
      end
    end
  endtask

  initial begin : stimulus
    int p;
    // predictor reset state
    tmr_cfg.preset_a            = 7'd15;
    tmr_cfg.preset_b            = 7'd30;
    tmr_cfg.preset_c            = 7'd60;
    tmr_cfg.ticks_per_second    = 10'd1000;
    tmr_cfg.flicker_half_period = 10'd500;
    tmr_cfg.scan_period         = 4'd10;
    last_key    = 3'd0;
    scan_cnt    = 4'd0;
    ms_cnt      = 10'd0;
    secs_left   = SECONDS_RESET;
    set_mode    = 1'b0;
    started     = 1'b0;
    preset_sel  = PRESET_IDX_B;
    flick_cnt   = 10'd0;
    flick_phase = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: stray key code at the first scan, nothing happens
    key_queue = '{3'd6, 3'd6, 3'd6, 3'd0, 3'd0};
    wait_drained();

    // zero periods scan, count and blink on every tick; presets at the ends
    write_all(7'd0, 7'd99, 7'd127, 10'd0, 10'd0, 4'd0);
    @(posedge clk_i);
    // set mode, walk the presets, leave with preset C, start, restart while
    // running, reload, stray codes, blinking set mode, leave with preset A
    key_queue = '{3'd0, 3'd3, 3'd4, 3'd0, 3'd4, 3'd0, 3'd4, 3'd4, 3'd0, 3'd4, 3'd3, 3'd0,
                  3'd1, 3'd1, 3'd0, 3'd1, 3'd2, 3'd7, 3'd5, 3'd6, 3'd0, 3'd3, 3'd4, 3'd3};
    wait_drained();

    // random phases with different idling and register settings
    for (p = 0; p < 6; p++) begin
      case (p)
        0: write_all(pick_preset(), pick_preset(), pick_preset(), 10'd1, 10'd1, 4'd1);
        4: write_all(7'd127, 7'd99, 7'd0, 10'd1023, 10'd1023, 4'd15);
        default: write_all(pick_preset(), pick_preset(), pick_preset(),
                           10'($urandom_range(1, 12)), 10'($urandom_range(1, 20)),
                           4'($urandom_range(1, 4)));
      endcase
      @(posedge clk_i);
      case (p)
        1:       begin send_idle_pct = 85; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 85; end
        3, 5:    begin send_idle_pct = 38; recv_stall_pct = 38; end
        default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      endcase
      if (p == 0) hold_armed = 1'b1;
      queue_key_runs(270);
      wait_drained();
    end

    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #8_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
